### src/occupancy_frontier_detect_unit_macros.svh
// Assertion macros used by the frontier detector RTL.
// Depends on nothing; included by the top level only.
`ifndef OCCUPANCY_FRONTIER_DETECT_UNIT_MACROS_SVH
`define OCCUPANCY_FRONTIER_DETECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ofd_pkg.sv
// Types, constants and the cell classifier of the frontier detector.
// Used by ofd_stencil and occupancy_frontier_detect_unit.
package ofd_pkg;

    // Field widths fixed by the interface.
    localparam int OCC_W   = 8;
    localparam int IDX_W   = 20;
    localparam int CNT_W   = 20;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    // Smallest legal map dimension.
    localparam int MIN_SIZE = 3;

    // Saturation value of the frontier count.
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Special occupancy values.
    localparam logic signed [OCC_W-1:0] OCC_UNKNOWN  = -8'sd1;
    localparam logic signed [OCC_W-1:0] OCC_OCCUPIED = 8'sd100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    // Two-bit class kept in the line store.
    typedef enum logic [1:0] {
        CLS_KNOWN    = 2'd0,
        CLS_UNKNOWN  = 2'd1,
        CLS_OCCUPIED = 2'd2
    } t_cls;

    // Four-neighbour stencil around the cell under decision.
    typedef struct packed {
        t_cls centre;
        t_cls left;
        t_cls right;
        t_cls up;
        t_cls down;
    } t_stencil;

    // Reduce an occupancy value to its class; anything not special is known.
    function automatic t_cls classify(input logic signed [OCC_W-1:0] occ);
        t_cls cls;
        if (occ == OCC_UNKNOWN) begin
            cls = CLS_UNKNOWN;
        end else if (occ == OCC_OCCUPIED) begin
            cls = CLS_OCCUPIED;
        end else begin
            cls = CLS_KNOWN;
        end
        return cls;
    endfunction

endpackage

### src/occupancy_frontier_detect_unit.sv
// Top level of the occupancy grid frontier detector: position tracking,
// line store, decision stage and output register. Uses ofd_pkg, ofd_stencil
// and the assertion macros of occupancy_frontier_detect_unit_macros.svh.
//
// The block takes one grid cell per clock cycle in raster order, while the
// input is not stalled, and keeps a sustained rate of one cell per cycle. A
// cell is registered into the decision stage at its transfer edge, and the
// result it causes then passes to the output register. The line store is a
// memory of 2 x 2^clog2(MAX_WIDTH) two-bit entries with one write and two
// reads per cycle, all on the transfer edge of a cell; it needs no clearing
// after reset. The decision for cell (x, y-1) is made when cell (x, y)
// arrives, so a frontier result lags its cell by one row. After the last cell
// of a map an end result carries the saturating frontier count. The input
// stall follows the output stall combinationally only while the decision
// stage holds a result that the output register cannot yet take.
`include "occupancy_frontier_detect_unit_macros.svh"

module occupancy_frontier_detect_unit
    import ofd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port.
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // Cell input channel.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [OCC_W-1:0] i_occupancy,
    input  logic                    i_first_cell,
    // Result output channel.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_is_frontier,
    output logic [IDX_W-1:0]        o_cell_index,
    output logic                    o_end_of_map,
    output logic [CNT_W-1:0]        o_frontier_count
);

    // Widths of sizes, positions and line store columns.
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = CW + 1;
    localparam int PW = HW + WW;

    // Configuration registers, held already clamped.
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;

    // Position state.
    logic [WW-1:0] r_col;
    logic [HW-1:0] r_row;

    // Decision stage.
    logic          r_s1_valid;
    logic [WW-1:0] r_s1_x;
    logic [HW-1:0] r_s1_y;
    t_cls          r_s1_cls;
    logic          r_s1_first;
    logic          r_s1_end;
    logic          r_s1_dec;
    logic          r_s1_x0;
    t_cls          r_rd_a;
    t_cls          r_rd_b;
    t_cls          r_left;
    t_cls          r_ctr;
    logic [CNT_W-1:0] r_count;

    // Output register.
    logic             r_out_valid;
    logic             r_out_frontier;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_end;
    logic [CNT_W-1:0] r_out_count;

    // Line store, two rows selected by row parity.
    t_cls          mem [2**AW];

    // Handshake signals.
    logic          accept;
    logic          out_free;
    logic          s1_has_result;
    logic          s1_leave;

    // Position of the incoming cell.
    logic [WW-1:0] col_start;
    logic [HW-1:0] row_start;
    logic [WW-1:0] cur_x;
    logic [HW-1:0] cur_y;
    logic [HW-1:0] row_wrap;
    logic [WW-1:0] next_x;
    logic [HW-1:0] next_y;
    logic          row_done;
    logic          map_done;
    t_cls          in_cls;

    // Line store addresses.
    logic [CW-1:0] col_addr;
    logic [CW-1:0] col_addr_p1;
    logic [AW-1:0] addr_wr;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    // Decision stage logic.
    t_stencil         stencil;
    logic             stencil_frontier;
    logic             s1_frontier;
    logic [CNT_W-1:0] count_base;
    logic [CNT_W-1:0] count_inc;
    logic [HW-1:0]    y_above;
    logic [PW-1:0]    row_base;
    logic [PW:0]      index_sum;

    // Configuration writes, clamped to the legal size range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(MAX_WIDTH);
            r_height <= HW'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAP_WIDTH: begin
                    if (32'(i_cfg_data) < MIN_SIZE) begin
                        r_width <= WW'(MIN_SIZE);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(i_cfg_data);
                    end
                end
                REG_MAP_HEIGHT: begin
                    if (32'(i_cfg_data) < MIN_SIZE) begin
                        r_height <= HW'(MIN_SIZE);
                    end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        r_height <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height <= HW'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: the decision stage empties into the output register, or
    // simply retires when its cell gives no result.
    assign out_free      = !r_out_valid || !i_out_stall;
    assign s1_has_result = s1_frontier || r_s1_end;
    assign s1_leave      = r_s1_valid && (out_free || !s1_has_result);
    assign o_in_stall    = r_s1_valid && !s1_leave;
    assign accept        = i_in_valid && !o_in_stall;

    // Position of the incoming cell, with restart and wrap-around.
    always_comb begin
        col_start = i_first_cell ? '0 : r_col;
        row_start = i_first_cell ? '0 : r_row;
        if (col_start >= r_width) begin
            cur_x    = '0;
            row_wrap = HW'(row_start + 1'b1);
        end else begin
            cur_x    = col_start;
            row_wrap = row_start;
        end
        cur_y    = (row_wrap >= r_height) ? '0 : row_wrap;
        next_x   = WW'(cur_x + 1'b1);
        next_y   = HW'(cur_y + 1'b1);
        row_done = next_x >= r_width;
        map_done = row_done && (next_y >= r_height);
        in_cls   = classify(i_occupancy);
    end

    // Position registers advance on every cell transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (!row_done) begin
                r_col <= next_x;
                r_row <= cur_y;
            end else if (!map_done) begin
                r_col <= '0;
                r_row <= next_y;
            end else begin
                r_col <= '0;
                r_row <= '0;
            end
        end
    end

    // Port A fetches the row above at x+1; port B fetches two rows up at x,
    // or the row above at column 0 when a row begins.
    always_comb begin
        col_addr    = cur_x[CW-1:0];
        col_addr_p1 = CW'(cur_x + 1'b1);
        addr_wr     = {cur_y[0], col_addr};
        addr_a      = {~cur_y[0], col_addr_p1};
        addr_b      = (cur_x == '0) ? {~cur_y[0], {CW{1'b0}}} : {cur_y[0], col_addr};
    end

    // Line store: reads return the contents before this cell's write.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[addr_wr] <= in_cls;
            r_rd_a       <= mem[addr_a];
            r_rd_b       <= mem[addr_b];
        end
    end

    // Decision stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_leave) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Decision stage payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x     <= cur_x;
            r_s1_y     <= cur_y;
            r_s1_cls   <= in_cls;
            r_s1_first <= i_first_cell;
            r_s1_end   <= map_done;
            r_s1_x0    <= cur_x == '0;
            r_s1_dec   <= (32'(cur_y) >= 2) && (cur_x != '0) && !row_done;
        end
    end

    // Sliding window over the row above.
    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            r_left <= r_s1_x0 ? r_rd_b : r_ctr;
            r_ctr  <= r_rd_a;
        end
    end

    // Stencil around cell (x, y-1).
    always_comb begin
        stencil.centre = r_ctr;
        stencil.left   = r_left;
        stencil.right  = r_rd_a;
        stencil.up     = r_rd_b;
        stencil.down   = r_s1_cls;
    end

    ofd_stencil u_stencil (
        .i_stencil  (stencil),
        .o_frontier (stencil_frontier)
    );

    // Count update and linear index of the decided cell.
    always_comb begin
        s1_frontier = r_s1_dec && stencil_frontier;
        count_base  = r_s1_first ? '0 : r_count;
        count_inc   = (s1_frontier && (count_base != COUNT_MAX)) ?
                      CNT_W'(count_base + 1'b1) : count_base;
        y_above     = HW'(r_s1_y - 1'b1);
        row_base    = PW'(y_above) * PW'(r_width);
        index_sum   = (PW + 1)'(row_base) + (PW + 1)'(r_s1_x);
    end

    // Frontier count, cleared after the map's end result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (s1_leave) begin
            r_count <= r_s1_end ? '0 : count_inc;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_leave && s1_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (s1_leave && s1_has_result) begin
            r_out_frontier <= s1_frontier;
            r_out_index    <= s1_frontier ? IDX_W'(index_sum) : '0;
            r_out_end      <= r_s1_end;
            r_out_count    <= count_inc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_frontier    = r_out_frontier;
    assign o_cell_index     = r_out_index;
    assign o_end_of_map     = r_out_end;
    assign o_frontier_count = r_out_count;

    // A result is either a frontier or an end of map, never both or neither.
    `OFD_ASSERT_NOW(a_result_kind, i_clk, i_rst_n, o_out_valid, o_is_frontier != o_end_of_map, "result is neither a single frontier nor a single end")
    // A frontier result always counts at least itself.
    `OFD_ASSERT_NOW(a_frontier_counted, i_clk, i_rst_n, o_out_valid && o_is_frontier, o_frontier_count != '0, "frontier result with zero count")
    // Retiring the map's last cell leaves the count cleared.
    `OFD_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, s1_leave && r_s1_end, r_count == '0, "count not cleared after end of map")

endmodule

### src/ofd_stencil.sv
// Frontier test on one four-neighbour stencil of cell classes.
// Depends on ofd_pkg for the class and stencil types.
module ofd_stencil
    import ofd_pkg::*;
(
    input  t_stencil i_stencil,
    output logic     o_frontier
);

    logic any_occupied;
    logic any_unknown;

    // Look at the four neighbours for obstacles and unexplored space.
    always_comb begin
        any_occupied = (i_stencil.left  == CLS_OCCUPIED) || (i_stencil.right == CLS_OCCUPIED) ||
                       (i_stencil.up    == CLS_OCCUPIED) || (i_stencil.down  == CLS_OCCUPIED);
        any_unknown  = (i_stencil.left  == CLS_UNKNOWN)  || (i_stencil.right == CLS_UNKNOWN)  ||
                       (i_stencil.up    == CLS_UNKNOWN)  || (i_stencil.down  == CLS_UNKNOWN);
    end

    // Any cell not unknown, next to unknown space and with no occupied neighbour, is a frontier.
    assign o_frontier = (i_stencil.centre != CLS_UNKNOWN) && !any_occupied && any_unknown;

endmodule

### verif/occupancy_frontier_detect_unit_tb.sv
// Self-checking testbench for occupancy_frontier_detect_unit, built on ofd_pkg.
// A directed table of small maps comes first, then random maps of many sizes,
// checked by a behavioral frontier predictor kept inside this file or by typed results.
`timescale 1ns / 100ps

module occupancy_frontier_detect_unit_tb;
    import ofd_pkg::*;

    localparam int TB_MAX_WIDTH  = 1024;
    localparam int TB_MAX_HEIGHT = 1024;
    localparam int RANDOM_CELLS  = 320;
    localparam int DIRECTED_LEN  = 23;

    // How a directed row is checked: by the predictor, by a typed result, or not at all.
    typedef enum logic [1:0] {
        CHK_PREDICT  = 2'd0,
        CHK_NONE     = 2'd1,
        CHK_FRONTIER = 2'd2,
        CHK_END      = 2'd3
    } t_check_mode;

    typedef struct packed {
        logic signed [OCC_W-1:0] occ;
        logic                    first_cell;
        t_check_mode             chk;
        logic [IDX_W-1:0]        index;
        logic [CNT_W-1:0]        count;
    } t_cell_row;

    typedef struct packed {
        logic             is_frontier;
        logic [IDX_W-1:0] cell_index;
        logic             end_of_map;
        logic [CNT_W-1:0] frontier_count;
    } t_map_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = REG_MAP_WIDTH;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [OCC_W-1:0] i_occupancy = '0;
    logic                    i_first_cell = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_is_frontier;
    logic [IDX_W-1:0]        o_cell_index;
    logic                    o_end_of_map;
    logic [CNT_W-1:0]        o_frontier_count;

    // Check mode that travels with the cell on the input channel.
    t_check_mode      cell_check = CHK_PREDICT;
    logic [IDX_W-1:0] cell_check_index = '0;
    logic [CNT_W-1:0] cell_check_count = '0;

    logic quiet = 1'b0;
    int   stall_left = 0;
    int   mismatch_count = 0;
    int   cells_sent = 0;

    // Predictor state: raw size registers, scan position, count, two rows of classes.
    logic [CFG_W-1:0] map_width_raw = CFG_W'(TB_MAX_WIDTH);
    logic [CFG_W-1:0] map_height_raw = CFG_W'(TB_MAX_HEIGHT);
    int               scan_col = 0;
    int               scan_row = 0;
    logic [CNT_W-1:0] frontiers_found = '0;
    t_cls             row_class [0:1][0:TB_MAX_WIDTH-1];
    t_map_result      awaited_results [$];

    // Directed maps: a 3x3 map with one frontier, a restarted fragment, then a
    // 4x3 map where an occupied neighbour and an unknown centre block frontiers.
    t_cell_row directed_cells [0:DIRECTED_LEN-1] = '{
        '{8'sd0,        1'b1, CHK_NONE,     20'd0, 20'd0},
        '{OCC_UNKNOWN,  1'b0, CHK_NONE,     20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_NONE,     20'd0, 20'd0},
        '{8'sd5,        1'b0, CHK_NONE,     20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_NONE,     20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_NONE,     20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_NONE,     20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_FRONTIER, 20'd4, 20'd1},
        '{8'sd0,        1'b0, CHK_END,      20'd0, 20'd1},
        '{OCC_OCCUPIED, 1'b1, CHK_PREDICT,  20'd0, 20'd0},
        '{OCC_UNKNOWN,  1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sh80,       1'b1, CHK_PREDICT,  20'd0, 20'd0},
        '{OCC_OCCUPIED, 1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{OCC_UNKNOWN,  1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sd127,      1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{OCC_UNKNOWN,  1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sd99,       1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{OCC_UNKNOWN,  1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sd1,        1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sd101,      1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'shFE,       1'b0, CHK_PREDICT,  20'd0, 20'd0},
        '{8'sd0,        1'b0, CHK_END,      20'd0, 20'd0}
    };

    occupancy_frontier_detect_unit #(
        .MAX_WIDTH  (TB_MAX_WIDTH),
        .MAX_HEIGHT (TB_MAX_HEIGHT)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_occupancy      (i_occupancy),
        .i_first_cell     (i_first_cell),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_frontier    (o_is_frontier),
        .o_cell_index     (o_cell_index),
        .o_end_of_map     (o_end_of_map),
        .o_frontier_count (o_frontier_count)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit in case the block hangs.
    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Size registers hold raw values; the effective size is clamped to the legal range.
    function automatic int clamp_dim(input logic [CFG_W-1:0] raw, input int limit);
        if (raw < MIN_SIZE) begin
            return MIN_SIZE;
        end
        if (raw > limit) begin
            return limit;
        end
        return raw;
    endfunction

    // Advance the predicted scan by one cell; returns 1 when a result is due.
    function automatic bit predict_frontier_step(input logic signed [OCC_W-1:0] occ,
                                                 input logic restart,
                                                 output t_map_result res);
        t_cls cls;
        t_cls centre;
        t_cls left_n;
        t_cls right_n;
        t_cls up_n;
        int   w;
        int   h;
        int   x;
        int   y;
        int   cur;
        bit   occupied_near;
        bit   unknown_near;
        bit   produced;

        w = clamp_dim(map_width_raw, TB_MAX_WIDTH);
        h = clamp_dim(map_height_raw, TB_MAX_HEIGHT);
        produced = 1'b0;
        res = '0;
        unique case (occ)
            OCC_UNKNOWN:  cls = CLS_UNKNOWN;
            OCC_OCCUPIED: cls = CLS_OCCUPIED;
            default:      cls = CLS_KNOWN;
        endcase

        if (restart) begin
            scan_col = 0;
            scan_row = 0;
            frontiers_found = '0;
        end
        // A size change can leave the position outside the map; wrap it.
        if (scan_col >= w) begin
            scan_col = 0;
            scan_row = scan_row + 1;
        end
        if (scan_row >= h) begin
            scan_row = 0;
        end
        x = scan_col;
        y = scan_row;
        cur = y % 2;

        // Decide on the cell one row up, away from the border.
        if (y >= 2 && x >= 1 && x + 1 < w) begin
            centre  = row_class[1 - cur][x];
            left_n  = row_class[1 - cur][x - 1];
            right_n = row_class[1 - cur][x + 1];
            up_n    = row_class[cur][x];
            if (centre != CLS_UNKNOWN) begin
                occupied_near = (left_n == CLS_OCCUPIED) || (right_n == CLS_OCCUPIED) ||
                                (up_n == CLS_OCCUPIED) || (cls == CLS_OCCUPIED);
                unknown_near  = (left_n == CLS_UNKNOWN) || (right_n == CLS_UNKNOWN) ||
                                (up_n == CLS_UNKNOWN) || (cls == CLS_UNKNOWN);
                if (!occupied_near && unknown_near) begin
                    if (frontiers_found != COUNT_MAX) begin
                        frontiers_found = frontiers_found + 1'b1;
                    end
                    res.is_frontier    = 1'b1;
                    res.cell_index     = IDX_W'((y - 1) * w + x);
                    res.frontier_count = frontiers_found;
                    produced = 1'b1;
                end
            end
        end
        row_class[cur][x] = cls;

        // Step the position; the last cell of the map closes it with the count.
        scan_col = x + 1;
        if (scan_col >= w) begin
            scan_col = 0;
            scan_row = y + 1;
            if (scan_row >= h) begin
                res = '0;
                res.end_of_map     = 1'b1;
                res.frontier_count = frontiers_found;
                produced = 1'b1;
                scan_row = 0;
                frontiers_found = '0;
            end
        end
        return produced;
    endfunction

    // Track register writes, predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin : result_check
        t_map_result predicted;
        t_map_result want;
        bit          produced;

        if (!i_rst_n) begin
            map_width_raw = CFG_W'(TB_MAX_WIDTH);
            map_height_raw = CFG_W'(TB_MAX_HEIGHT);
            scan_col = 0;
            scan_row = 0;
            frontiers_found = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MAP_WIDTH) begin
                    map_width_raw = i_cfg_data;
                end else if (i_cfg_index == REG_MAP_HEIGHT) begin
                    map_height_raw = i_cfg_data;
                end
            end

            if (i_in_valid && !o_in_stall) begin
                produced = predict_frontier_step(i_occupancy, i_first_cell, predicted);
                unique case (cell_check)
                    CHK_PREDICT: begin
                        if (produced) begin
                            awaited_results.insert(awaited_results.size(), predicted);
                        end
                    end
                    CHK_FRONTIER: begin
                        awaited_results.insert(awaited_results.size(),
                                               {1'b1, cell_check_index, 1'b0,
                                                cell_check_count});
                    end
                    CHK_END: begin
                        awaited_results.insert(awaited_results.size(),
                                               {1'b0, {IDX_W{1'b0}}, 1'b1,
                                                cell_check_count});
                    end
                    default: begin
                    end
                endcase
            end

            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with nothing awaited");
                end else begin
                    want = awaited_results.pop_front();
                    if (o_is_frontier !== want.is_frontier) begin
                        report_mismatch($sformatf("is_frontier %b, want %b",
                                                  o_is_frontier, want.is_frontier));
                    end
                    if (o_cell_index !== want.cell_index) begin
                        report_mismatch($sformatf("cell_index %0d, want %0d",
                                                  o_cell_index, want.cell_index));
                    end
                    if (o_end_of_map !== want.end_of_map) begin
                        report_mismatch($sformatf("end_of_map %b, want %b",
                                                  o_end_of_map, want.end_of_map));
                    end
                    if (o_frontier_count !== want.frontier_count) begin
                        report_mismatch($sformatf("frontier_count %0d, want %0d",
                                                  o_frontier_count, want.frontier_count));
                    end
                end
            end
        end
    end

    // Output back-pressure in bursts of random length, off in the quiet tail.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 99) < 15) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one cell, maybe after an idle burst, and hold it until its transfer.
    task automatic send_cell(input logic signed [OCC_W-1:0] occ, input logic restart,
                             input t_check_mode chk, input logic [IDX_W-1:0] index,
                             input logic [CNT_W-1:0] count);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_occupancy      <= occ;
        i_first_cell     <= restart;
        cell_check       <= chk;
        cell_check_index <= index;
        cell_check_count <= count;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        cells_sent++;
    endtask

    // Stop sending, wait for every awaited result, then let the pipeline settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAP_WIDTH;
        i_cfg_data  <= raw_w;
        @(posedge i_clk);
        i_cfg_index <= REG_MAP_HEIGHT;
        i_cfg_data  <= raw_h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly unknown or free cells so that frontiers are common; some occupied and odd values.
    function automatic logic signed [OCC_W-1:0] random_occupancy();
        int                      pick;
        logic signed [OCC_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            v = OCC_UNKNOWN;
        end else if (pick < 40) begin
            v = OCC_OCCUPIED;
        end else if (pick < 48) begin
            v = OCC_W'($urandom_range(0, 255));
        end else begin
            v = OCC_W'($urandom_range(0, 99));
        end
        return v;
    endfunction

    // Small map sizes; raw values below the minimum now and then.
    function automatic logic [CFG_W-1:0] pick_size();
        logic [CFG_W-1:0] v;
        if ($urandom_range(0, 9) == 0) begin
            v = CFG_W'($urandom_range(0, 2));
        end else begin
            v = CFG_W'($urandom_range(3, 9));
        end
        return v;
    endfunction

    // Set a size while idle and stream whole maps, each opened by first_cell.
    task automatic run_maps(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h,
                            input int maps, input bit restarts);
        int   total;
        int   m;
        int   c;
        logic restart;
        drain_results();
        write_size(raw_w, raw_h);
        total = clamp_dim(raw_w, TB_MAX_WIDTH) * clamp_dim(raw_h, TB_MAX_HEIGHT);
        for (m = 0; m < maps; m++) begin
            for (c = 0; c < total; c++) begin
                restart = (c == 0) || (restarts && $urandom_range(0, 199) == 0);
                send_cell(random_occupancy(), restart, CHK_PREDICT, '0, '0);
            end
        end
    endtask

    initial begin : stimulus
        int k;
        int waited;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed maps; raw sizes below the minimum clamp to 3x3.
        drain_results();
        write_size(11'd0, 11'd2);
        for (k = 0; k < DIRECTED_LEN; k++) begin
            if (k == 11) begin
                drain_results();
                write_size(11'd4, 11'd3);
            end
            send_cell(directed_cells[k].occ, directed_cells[k].first_cell,
                      directed_cells[k].chk, directed_cells[k].index,
                      directed_cells[k].count);
        end

        // Random small maps with occasional restarts in the middle of a map.
        while (cells_sent < RANDOM_CELLS) begin
            run_maps(pick_size(), pick_size(), $urandom_range(1, 3), 1'b1);
        end

        // Shrink the map mid-scan: the column and the row both wrap, the count is kept.
        drain_results();
        write_size(11'd8, 11'd6);
        for (k = 0; k < 20; k++) begin
            send_cell(random_occupancy(), k == 0, CHK_PREDICT, '0, '0);
        end
        drain_results();
        write_size(11'd4, 11'd3);
        for (k = 0; k < 30; k++) begin
            send_cell(random_occupancy(), 1'b0, CHK_PREDICT, '0, '0);
        end

        // Widest map (raw width clamps high), scanned only along its first row.
        drain_results();
        write_size(11'd2047, 11'd3);
        for (k = 0; k < 24; k++) begin
            send_cell(random_occupancy(), k == 0, CHK_PREDICT, '0, '0);
        end

        // Tallest map (raw height clamps high), scanned over its first rows.
        drain_results();
        write_size(11'd3, 11'd2047);
        for (k = 0; k < 30; k++) begin
            send_cell(random_occupancy(), k == 0, CHK_PREDICT, '0, '0);
        end

        // Final stretch without idling on either side.
        quiet <= 1'b1;
        run_maps(11'd5, 11'd5, 3, 1'b0);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (awaited_results.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d awaited results never arrived",
                                      awaited_results.size()));
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
